### design/tffc_pkg.sv
// ----------------------------------------------------------------------------
// tffc_pkg
// Shared constants, types and helpers for the thermal frame false-colour block.
// ----------------------------------------------------------------------------
package tffc_pkg;

  // Frame geometry and sample format
  localparam int unsigned FRAME_PIXELS = 64;
  localparam int unsigned TEMP_BITS    = 12;
  localparam int unsigned IDX_W        = $clog2(FRAME_PIXELS);

  // N*t and the frame sum share one signed width; differences need one more bit
  localparam int unsigned SUM_W = TEMP_BITS + IDX_W;
  localparam int unsigned DIF_W = SUM_W + 1;
  // Numerator and denominator are never negative and stay below 2^SUM_W
  localparam int unsigned NUM_W = SUM_W;

  // Ramp quotients are 0..10, so four quotient bits per lane
  localparam int unsigned QUO_W  = 4;
  localparam int unsigned STEP_W = $clog2(QUO_W);
  localparam int unsigned REM_W  = NUM_W + QUO_W;

  // Colour fields
  localparam int unsigned COL_W = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_PIXELS - 1);

  // Ramp gains and offset
  localparam logic [REM_W-1:0] K_HI      = REM_W'(10);
  localparam logic [REM_W-1:0] K_LO      = REM_W'(6);
  localparam logic [QUO_W-1:0] BLUE_FLAT = QUO_W'(6);
  localparam logic [COL_W-1:0] RAMP_BASE = COL_W'(15);

  localparam logic signed [TEMP_BITS-1:0] TEMP_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
  localparam logic signed [TEMP_BITS-1:0] TEMP_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_READ,
    ST_CALC,
    ST_DIV
  } tffc_state_e;

  // Divider sequencer
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_LOAD,
    DV_RUN,
    DV_DONE
  } tffc_div_state_e;

  // Request to the ratio divider
  typedef struct packed {
    logic             above;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } tffc_div_req_t;

  // Quotients returned by the ratio divider
  typedef struct packed {
    logic [QUO_W-1:0] red;
    logic [QUO_W-1:0] blue;
  } tffc_div_rsp_t;

  // N * t as a signed value
  function automatic logic signed [SUM_W-1:0] scale_n(input logic signed [TEMP_BITS-1:0] t);
    logic signed [SUM_W-1:0] te;
    te = SUM_W'(t);
    return te * SUM_W'(FRAME_PIXELS);
  endfunction

endpackage

### design/thermal_frame_false_color.sv
// ----------------------------------------------------------------------------
// thermal_frame_false_color
// Collects a frame of signed temperature samples and maps it to a red/blue
// false-colour ramp around the frame mean.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while start_i is high and busy_o is low, in
// raster order, with the frame store written and min/max/sum tracked on every
// transfer. The transfer of the last sample of a frame raises busy_o and starts
// the colour pass: each pixel is read from the frame store, its ratio terms
// formed and its two ramp quotients found by the shared two-lane divider (load,
// then one quotient bit per cycle, then hand-back); the next pixel is read only
// once the last one has been handed back. Each pixel is shown for one cycle with
// result_valid_o high; the receiver cannot stall, so it must take every strobe.
// busy_o falls with the final pixel's strobe and the next frame may start in
// that same cycle.
// ----------------------------------------------------------------------------
module thermal_frame_false_color import tffc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [TEMP_BITS-1:0] temperature_i,
  output logic                        result_valid_o,
  output logic [IDX_W-1:0]            pixel_index_o,
  output logic [COL_W-1:0]            red_o,
  output logic [COL_W-1:0]            blue_o,
  output logic                        last_o
);

  tffc_state_e state_q, state_d;
  logic [IDX_W-1:0]            count_q, count_d;
  logic signed [TEMP_BITS-1:0] min_q, min_d, max_q, max_d;
  logic signed [SUM_W-1:0]     sum_q, sum_d;

  logic             valid_q, valid_d, last_q, last_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [COL_W-1:0] red_q, red_d, blue_q, blue_d;

  logic                        accept, ram_re;
  logic [TEMP_BITS-1:0]        ram_rdata;
  logic signed [TEMP_BITS-1:0] t_rd;
  logic signed [SUM_W-1:0]     nt, nmin, nmax;
  logic signed [DIF_W-1:0]     num_hi, den_hi, num_lo, den_lo;
  logic                        div_start, div_done;
  tffc_div_req_t               div_req;
  tffc_div_rsp_t               div_rsp;
  logic [IDX_W-1:0]            count_inc;

  assign busy_o = (state_q != ST_COLLECT);
  assign accept = start_i && !busy_o;

  assign count_inc = (count_q == LAST_IDX) ? '0 : count_q + 1'b1;

  // Frame store
  tffc_ram #(
    .WIDTH (TEMP_BITS),
    .DEPTH (FRAME_PIXELS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (count_q),
    .wdata_i (temperature_i),
    .re_i    (ram_re),
    .raddr_i (count_q),
    .rdata_o (ram_rdata)
  );

  // Ratio terms: N*t against the sum decides the side of the mean
  assign t_rd   = ram_rdata;
  assign nt     = scale_n(t_rd);
  assign nmin   = scale_n(min_q);
  assign nmax   = scale_n(max_q);
  assign num_hi = DIF_W'(nt)   - DIF_W'(sum_q);
  assign den_hi = DIF_W'(nmax) - DIF_W'(sum_q);
  assign num_lo = DIF_W'(nt)   - DIF_W'(nmin);
  assign den_lo = DIF_W'(sum_q) - DIF_W'(nmin);

  always_comb begin
    div_req.above = (nt >= sum_q);
    if (div_req.above) begin
      div_req.num = num_hi[NUM_W-1:0];
      div_req.den = den_hi[NUM_W-1:0];
    end else begin
      div_req.num = num_lo[NUM_W-1:0];
      div_req.den = den_lo[NUM_W-1:0];
    end
  end

  tffc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .rsp_o   (div_rsp)
  );

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      count_q <= '0;
      min_q   <= TEMP_MAX;
      max_q   <= TEMP_MIN;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      min_q   <= min_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    red_q  <= red_d;
    blue_q <= blue_d;
    last_q <= last_d;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    min_d     = min_q;
    max_d     = max_q;
    sum_d     = sum_q;
    valid_d   = 1'b0;
    idx_d     = idx_q;
    red_d     = red_q;
    blue_d    = blue_q;
    last_d    = last_q;
    ram_re    = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        if (accept) begin
          if (temperature_i < min_q) begin
            min_d = temperature_i;
          end
          if (temperature_i > max_q) begin
            max_d = temperature_i;
          end
          sum_d   = sum_q + SUM_W'(temperature_i);
          count_d = count_inc;
          if (count_q == LAST_IDX) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          valid_d = 1'b1;
          idx_d   = count_q;
          last_d  = (count_q == LAST_IDX);
          // Read data and statistics are held, so the side of the mean still stands
          if (div_req.above) begin
            red_d  = RAMP_BASE + COL_W'(div_rsp.red);
            blue_d = COL_W'(div_rsp.blue);
          end else begin
            red_d  = COL_W'(div_rsp.red);
            blue_d = RAMP_BASE + COL_W'(div_rsp.blue);
          end
          count_d = count_inc;
          if (count_q == LAST_IDX) begin
            // Frame done: statistics back to their idle values
            min_d   = TEMP_MAX;
            max_d   = TEMP_MIN;
            sum_d   = '0;
            state_d = ST_COLLECT;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  assign result_valid_o = valid_q;
  assign pixel_index_o  = idx_q;
  assign red_o          = red_q;
  assign blue_o         = blue_q;
  assign last_o         = last_q;

endmodule

### design/tffc_ram.sv
// ----------------------------------------------------------------------------
// tffc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tffc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tffc_div.sv
// ----------------------------------------------------------------------------
// tffc_div
// Two-lane restoring divider: floor(k*num/den) for the red and blue ramps (blue
// above the mean uses den-num), one quotient bit per lane per cycle while running.
// ----------------------------------------------------------------------------
module tffc_div import tffc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tffc_div_req_t req_i,
  output logic          done_o,
  output tffc_div_rsp_t rsp_o
);

  tffc_div_state_e state_q, state_d;
  tffc_div_req_t   req_q, req_d;
  logic [REM_W-1:0]  rem_r_q, rem_r_d, rem_b_q, rem_b_d, dvs_q, dvs_d;
  logic [QUO_W-1:0]  quo_r_q, quo_r_d, quo_b_q, quo_b_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              den_zero;

  assign den_zero = (req_q.den == '0);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    rem_r_q <= rem_r_d;
    rem_b_q <= rem_b_d;
    dvs_q   <= dvs_d;
    quo_r_q <= quo_r_d;
    quo_b_q <= quo_b_d;
    step_q  <= step_d;
  end

  // Sequencing and one restoring step per lane
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    rem_r_d = rem_r_q;
    rem_b_d = rem_b_q;
    dvs_d   = dvs_q;
    quo_r_d = quo_r_q;
    quo_b_d = quo_b_q;
    step_d  = step_q;
    done_o  = 1'b0;
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = DV_LOAD;
        end
      end
      DV_LOAD: begin
        // Above the mean: red 10*s, blue 6*(1-s). Below: red 6*s, blue 10*s.
        if (req_q.above) begin
          rem_r_d = REM_W'(req_q.num) * K_HI;
          rem_b_d = REM_W'(req_q.den - req_q.num) * K_LO;
        end else begin
          rem_r_d = REM_W'(req_q.num) * K_LO;
          rem_b_d = REM_W'(req_q.num) * K_HI;
        end
        dvs_d   = REM_W'(req_q.den) << (QUO_W - 1);
        quo_r_d = '0;
        quo_b_d = '0;
        step_d  = STEP_W'(QUO_W - 1);
        state_d = DV_RUN;
      end
      DV_RUN: begin
        if (rem_r_q >= dvs_q) begin
          rem_r_d = rem_r_q - dvs_q;
          quo_r_d = {quo_r_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_r_d = {quo_r_q[QUO_W-2:0], 1'b0};
        end
        if (rem_b_q >= dvs_q) begin
          rem_b_d = rem_b_q - dvs_q;
          quo_b_d = {quo_b_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_b_d = {quo_b_q[QUO_W-2:0], 1'b0};
        end
        dvs_d = dvs_q >> 1;
        if (step_q == '0) begin
          state_d = DV_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      DV_DONE: begin
        done_o  = 1'b1;
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  // Zero denominator means s = 0: blue stays at its flat value above the mean
  always_comb begin
    if (den_zero) begin
      rsp_o.red  = '0;
      rsp_o.blue = req_q.above ? BLUE_FLAT : '0;
    end else begin
      rsp_o.red  = quo_r_q;
      rsp_o.blue = quo_b_q;
    end
  end

endmodule
